// File: hw/rtl/yrr_pkg.sv
// Shared types, register indexes and constants for the YUYV to RGB ring overlay.
package yrr_pkg;

    localparam int MAX_FRAME_SIDE_DEF = 2048;
    localparam int LANES              = 2;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 12;

    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_X       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_Y       = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_RING_RADIUS    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_RING_THICKNESS = 3'd5;

    localparam logic [11:0] RST_FRAME_WIDTH    = 12'd640;
    localparam logic [11:0] RST_FRAME_HEIGHT   = 12'd480;
    localparam logic [10:0] RST_CENTER_X       = 11'd320;
    localparam logic [10:0] RST_CENTER_Y       = 11'd240;
    localparam logic [9:0]  RST_RING_RADIUS    = 10'd50;
    localparam logic [9:0]  RST_RING_THICKNESS = 10'd5;
    localparam logic [19:0] RST_RAD_SQ   = 20'(RST_RING_RADIUS * RST_RING_RADIUS);
    localparam logic [19:0] RST_INNER_SQ =
        20'((RST_RING_RADIUS - RST_RING_THICKNESS) * (RST_RING_RADIUS - RST_RING_THICKNESS));

    typedef struct packed {
        logic [7:0] luma_first;
        logic [7:0] chroma_blue;
        logic [7:0] luma_second;
        logic [7:0] chroma_red;
        logic       last_in_frame;
    } t_in_item;

    typedef struct packed {
        logic [7:0] red_left;
        logic [7:0] green_left;
        logic [7:0] blue_left;
        logic [7:0] red_right;
        logic [7:0] green_right;
        logic [7:0] blue_right;
        logic       frame_end;
    } t_out_item;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_rgb;

    // ring geometry as the lanes see it, squares precomputed from the registers
    typedef struct packed {
        logic [10:0] center_x;
        logic [10:0] center_y;
        logic [19:0] rad_sq;
        logic [19:0] inner_sq;
        logic        inner_neg;
    } t_ring_cfg;

endpackage

// File: hw/rtl/yrr_lane.sv
// One pixel lane: BT.601 conversion and ring test over two register stages.
module yrr_lane #(
    parameter int MAX_FRAME_SIDE = yrr_pkg::MAX_FRAME_SIDE_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_en2,
    input  logic                               i_en3,
    input  logic [7:0]                         i_luma,
    input  logic [7:0]                         i_cb,
    input  logic [7:0]                         i_cr,
    input  logic [$clog2(MAX_FRAME_SIDE):0]    i_x,
    input  logic [$clog2(MAX_FRAME_SIDE):0]    i_y,
    input  yrr_pkg::t_ring_cfg                 i_ring,
    output yrr_pkg::t_rgb                      o_pix
);
    import yrr_pkg::*;

    localparam int XW = $clog2(MAX_FRAME_SIDE) + 1;
    localparam int DW = ((XW > 11) ? XW : 11) + 1;
    localparam int SQW = 2 * DW;

    function automatic logic [7:0] clamp_q8(input logic signed [19:0] s);
        logic [7:0] res;
        if (s[19]) begin
            res = 8'd0;
        end else if (|s[18:16]) begin
            res = 8'd255;
        end else begin
            res = s[15:8];
        end
        return res;
    endfunction

    logic signed [8:0]     c;
    logic signed [8:0]     d;
    logic signed [8:0]     e;
    logic signed [DW-1:0]  dx;
    logic signed [DW-1:0]  dy;
    logic signed [SQW-1:0] dx_sq;
    logic signed [SQW-1:0] dy_sq;

    // chroma minus 128: flip the top bit and sign-extend
    assign c  = $signed({1'b0, i_luma} - 9'd16);
    assign d  = $signed({~i_cb[7], ~i_cb[7], i_cb[6:0]});
    assign e  = $signed({~i_cr[7], ~i_cr[7], i_cr[6:0]});
    assign dx = $signed(DW'(i_x)) - $signed(DW'(i_ring.center_x));
    assign dy = $signed(DW'(i_y)) - $signed(DW'(i_ring.center_y));
    assign dx_sq = SQW'(dx) * SQW'(dx);
    assign dy_sq = SQW'(dy) * SQW'(dy);

    logic signed [19:0] r_pc;
    logic signed [19:0] r_pre;
    logic signed [19:0] r_pgd;
    logic signed [19:0] r_pge;
    logic signed [19:0] r_pbd;
    logic [SQW-1:0]     r_dx_sq;
    logic [SQW-1:0]     r_dy_sq;

    always_ff @(posedge i_clk) begin
        if (i_en2) begin
            r_pc    <= 20'(c) * 20'sd298;
            r_pre   <= 20'(e) * 20'sd409;
            r_pgd   <= 20'(d) * 20'sd100;
            r_pge   <= 20'(e) * 20'sd208;
            r_pbd   <= 20'(d) * 20'sd516;
            r_dx_sq <= unsigned'(dx_sq);
            r_dy_sq <= unsigned'(dy_sq);
        end
    end

    logic signed [19:0] sum_r;
    logic signed [19:0] sum_g;
    logic signed [19:0] sum_b;
    logic [SQW:0]       dist_sq;
    logic               on_ring;
    t_rgb               n_pix;
    t_rgb               r_pix;

    assign sum_r   = r_pc + r_pre + 20'sd128;
    assign sum_g   = r_pc - r_pgd - r_pge + 20'sd128;
    assign sum_b   = r_pc + r_pbd + 20'sd128;
    assign dist_sq = (SQW+1)'(r_dx_sq) + (SQW+1)'(r_dy_sq);
    assign on_ring = (dist_sq < (SQW+1)'(i_ring.rad_sq)) &&
                     (i_ring.inner_neg || (dist_sq > (SQW+1)'(i_ring.inner_sq)));

    always_comb begin
        if (on_ring) begin
            n_pix = '{red: 8'd255, green: 8'd0, blue: 8'd0};
        end else begin
            n_pix = '{red: clamp_q8(sum_r), green: clamp_q8(sum_g), blue: clamp_q8(sum_b)};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en3) begin
            r_pix <= n_pix;
        end
    end

    assign o_pix = r_pix;

endmodule

// File: hw/rtl/yuyv_to_rgb_ring_overlay.sv
// YUYV macropixel to RGB pair converter with a red ring overlay.
// One item (a YUYV pair) is taken per clock while the output is not stalled, and one RGB pair
// comes out per item, registered through the three-stage pipeline (capture, products, sums and
// clamp) in which two pixel lanes run side by side, and each stage moves on as soon as the one
// after it is free. Column and row counters place each pair in the frame. Ring squares are
// registered from the radius and thickness registers after those are written.
module yuyv_to_rgb_ring_overlay #(
    parameter int MAX_FRAME_SIDE = yrr_pkg::MAX_FRAME_SIDE_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  yrr_pkg::t_in_item                  i_in_data,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output yrr_pkg::t_out_item                 o_out_data,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [yrr_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [yrr_pkg::CFG_DATA_W-1:0]     i_cfg_data
);
    import yrr_pkg::*;

    localparam int CW = $clog2(MAX_FRAME_SIDE);
    localparam int XW = CW + 1;
    localparam int SW = (XW > 12) ? XW : 12;

    // configuration registers
    logic [11:0] r_frame_width;
    logic [11:0] r_frame_height;
    logic [10:0] r_center_x;
    logic [10:0] r_center_y;
    logic [9:0]  r_radius;
    logic [9:0]  r_thickness;
    logic [19:0] r_rad_sq;
    logic [19:0] r_inner_sq;
    logic        r_inner_neg;

    logic signed [10:0] inner;
    assign inner = $signed({1'b0, r_radius}) - $signed({1'b0, r_thickness});

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= RST_FRAME_WIDTH;
            r_frame_height <= RST_FRAME_HEIGHT;
            r_center_x     <= RST_CENTER_X;
            r_center_y     <= RST_CENTER_Y;
            r_radius       <= RST_RING_RADIUS;
            r_thickness    <= RST_RING_THICKNESS;
            r_rad_sq       <= RST_RAD_SQ;
            r_inner_sq     <= RST_INNER_SQ;
            r_inner_neg    <= 1'b0;
        end else begin
            r_rad_sq    <= 20'(r_radius) * 20'(r_radius);
            r_inner_sq  <= 20'(inner[9:0]) * 20'(inner[9:0]);
            r_inner_neg <= inner[10];
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_FRAME_WIDTH:    r_frame_width  <= i_cfg_data;
                    CFG_FRAME_HEIGHT:   r_frame_height <= i_cfg_data;
                    CFG_CENTER_X:       r_center_x     <= i_cfg_data[10:0];
                    CFG_CENTER_Y:       r_center_y     <= i_cfg_data[10:0];
                    CFG_RING_RADIUS:    r_radius       <= i_cfg_data[9:0];
                    CFG_RING_THICKNESS: r_thickness    <= i_cfg_data[9:0];
                    default: ;
                endcase
            end
        end
    end

    // pipeline flow control: each stage moves when it is empty or the next one moves
    logic r_v1;
    logic r_v2;
    logic r_v3;
    logic adv1;
    logic adv2;
    logic adv3;
    logic in_acc;

    assign adv3   = !r_v3 || i_out_ready;
    assign adv2   = !r_v2 || adv3;
    assign adv1   = !r_v1 || adv2;
    assign in_acc = i_in_valid && adv1;
    assign o_in_ready  = adv1;
    assign o_out_valid = r_v3;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (adv1) r_v1 <= i_in_valid;
            if (adv2) r_v2 <= r_v1;
            if (adv3) r_v3 <= r_v2;
        end
    end

    // frame position
    logic [CW-1:0] r_col;
    logic [CW-1:0] r_row;
    logic [CW-1:0] n_col;
    logic [CW-1:0] n_row;
    logic [SW-1:0] w_eff;
    logic [SW-1:0] h_eff;
    logic          col_wrap;
    logic          row_wrap;
    logic          n_end;

    assign w_eff = (SW'(r_frame_width) > SW'(MAX_FRAME_SIDE)) ?
                   SW'(MAX_FRAME_SIDE) : SW'(r_frame_width);
    assign h_eff = (SW'(r_frame_height) > SW'(MAX_FRAME_SIDE)) ?
                   SW'(MAX_FRAME_SIDE) : SW'(r_frame_height);
    assign col_wrap = (SW'(r_col) + SW'(2)) >= w_eff;
    assign row_wrap = (SW'(r_row) + SW'(1)) >= h_eff;

    always_comb begin
        n_col = r_col;
        n_row = r_row;
        n_end = i_in_data.last_in_frame;
        if (i_in_data.last_in_frame) begin
            n_col = '0;
            n_row = '0;
        end else if (col_wrap) begin
            n_col = '0;
            if (row_wrap) begin
                n_row = '0;
                n_end = 1'b1;
            end else begin
                n_row = r_row + CW'(1);
            end
        end else begin
            n_col = r_col + CW'(2);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (in_acc) begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    // capture stage
    t_in_item      r_s1_in;
    logic [CW-1:0] r_s1_col;
    logic [CW-1:0] r_s1_row;
    logic          r_s1_end;
    logic          r_s2_end;
    logic          r_s3_end;

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_in  <= i_in_data;
            r_s1_col <= r_col;
            r_s1_row <= r_row;
            r_s1_end <= n_end;
        end
        if (adv2 && r_v1) r_s2_end <= r_s1_end;
        if (adv3 && r_v2) r_s3_end <= r_s2_end;
    end

    t_ring_cfg ring;
    assign ring = '{center_x:  r_center_x,
                    center_y:  r_center_y,
                    rad_sq:    r_rad_sq,
                    inner_sq:  r_inner_sq,
                    inner_neg: r_inner_neg};

    logic [7:0] lane_luma [LANES];
    t_rgb       lane_pix  [LANES];

    assign lane_luma[0] = r_s1_in.luma_first;
    assign lane_luma[1] = r_s1_in.luma_second;

    for (genvar l = 0; l < LANES; l++) begin : g_lane
        yrr_lane #(
            .MAX_FRAME_SIDE(MAX_FRAME_SIDE)
        ) u_lane (
            .i_clk  (i_clk),
            .i_en2  (adv2 && r_v1),
            .i_en3  (adv3 && r_v2),
            .i_luma (lane_luma[l]),
            .i_cb   (r_s1_in.chroma_blue),
            .i_cr   (r_s1_in.chroma_red),
            .i_x    (XW'(r_s1_col) + XW'(l)),
            .i_y    (XW'(r_s1_row)),
            .i_ring (ring),
            .o_pix  (lane_pix[l])
        );
    end

    // merge the two lanes into one result item
    assign o_out_data = '{red_left:    lane_pix[0].red,
                          green_left:  lane_pix[0].green,
                          blue_left:   lane_pix[0].blue,
                          red_right:   lane_pix[1].red,
                          green_right: lane_pix[1].green,
                          blue_right:  lane_pix[1].blue,
                          frame_end:   r_s3_end};

    a_col_even: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_col[0])
        else $error("column counter went odd");

    a_last_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && i_in_data.last_in_frame |=> (r_col == '0) && (r_row == '0))
        else $error("counters not cleared after last item of frame");

    a_full_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v1 && r_v2 && r_v3 && !i_out_ready |-> !o_in_ready)
        else $error("item taken while pipeline full and stalled");

    a_end_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && i_in_data.last_in_frame |=> r_s1_end)
        else $error("frame end flag lost at capture");

endmodule
